/* design/linear_blend_vertex_skinner_macros.svh */
// Assertion macros for the vertex skinner
`ifndef LINEAR_BLEND_VERTEX_SKINNER_MACROS_SVH
`define LINEAR_BLEND_VERTEX_SKINNER_MACROS_SVH

`ifndef NO_ASSERTIONS
`define LBVS_ASSERT_NEXT(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
		else $error("skinner check failed");
`define LBVS_ASSERT_NOW(lbl, clk, rstn, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
		else $error("skinner check failed");
`else
`define LBVS_ASSERT_NEXT(lbl, clk, rstn, a, b)
`define LBVS_ASSERT_NOW(lbl, clk, rstn, a, b)
`endif

`endif

/* design/lbvs_pkg.sv */
package lbvs_pkg;

	localparam int DEF_BONE_COUNT = 256;
	localparam int DEF_FRAC_BITS  = 16;
	localparam int WORDS_PER_BONE = 12;
	localparam int WORD_W         = 32;
	localparam int ROW_WORDS      = 4;
	localparam int INFLUENCES     = 4;
	localparam int WEIGHT_W       = 16;
	localparam int WEIGHT_FRAC    = 15;
	localparam int ACC_W          = 64;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_SKIN  = 1'b1;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic ok;
	} lbvs_ctl_t;

endpackage

/* design/linear_blend_vertex_skinner.sv */
// Four-bone linear blend vertex skinner.
// Input stream s_*: s_tuser 0 writes one palette word (bone, element, value),
// s_tuser 1 skins one vertex with four bone numbers and four Q1.15 weights.
// Output stream m_*: one transfer per skin item, xyz packed in m_tdata,
// m_tuser set when any coordinate was clipped to 32 bits.
// A write item gives no output. A skin item reads one bone matrix per cycle
// from the palette memory while the output is not stalled, so it holds the
// input until its last bone is read, when the next item can be taken.
// Results go through stages s1 to s6 and the output register; the
// arithmetic pipeline runs behind the palette read for the four influences.
// A palette write issued after a skin item is seen only by later items.
// Reset clears the sequencer and pipeline control; the palette is undefined
// until written. When m_tready is low with a result held, the whole pipeline
// freezes and s_tready drops until the result is taken.
module linear_blend_vertex_skinner import lbvs_pkg::*; #(
	parameter int BONE_COUNT = DEF_BONE_COUNT,
	parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// palette_bone, palette_element, palette_value, pos_x, pos_y, pos_z,
	// bone_indices, bone_weights, four zero bits
	input  logic [239:0] s_tdata,
	// req_type
	input  logic [0:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// skinned_x, skinned_y, skinned_z
	output logic [95:0]  m_tdata,
	// saturated
	output logic [0:0]   m_tuser
);

`include "linear_blend_vertex_skinner_macros.svh"

	localparam int AW = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1;

	logic                              advance, free, accept, load;
	logic [7:0]                        wr_bone;
	logic [3:0]                        wr_elem;
	logic [WORDS_PER_BONE-1:0]         we_mask;
	logic [AW-1:0]                     raddr;
	logic [WORDS_PER_BONE*WORD_W-1:0]  matrix_s1;
	lbvs_ctl_t                         ctl_s1;
	logic [WEIGHT_W-1:0]               weight_s1;
	logic [3*WORD_W-1:0]               pos_s1;
	logic                              done_s6;
	logic signed [ACC_W-1:0]           acc_s6 [3];
	logic                              m_valid_q;
	logic [95:0]                       m_data_q;
	logic                              m_sat_q;
	logic [2:0]                        clip;

	assign advance  = !m_valid_q || m_tready;
	assign s_tready = advance && free;
	assign accept   = s_tvalid && s_tready;
	assign load     = accept && (s_tuser[0] == REQ_SKIN);
	assign wr_bone  = s_tdata[7:0];
	assign wr_elem  = s_tdata[11:8];

	always_comb begin
		we_mask = '0;
		if (accept && (s_tuser[0] == REQ_WRITE) && ({1'b0, wr_bone} < 9'(BONE_COUNT)) &&
				(wr_elem < 4'(WORDS_PER_BONE)))
			we_mask = WORDS_PER_BONE'(1) << wr_elem;
	end

	lbvs_ram #(.LANE_W(WORD_W), .LANES(WORDS_PER_BONE), .DEPTH(BONE_COUNT)) u_palette (
		.clk     (clk),
		.we_mask (we_mask),
		.waddr   (wr_bone[AW-1:0]),
		.wdata   ({WORDS_PER_BONE{s_tdata[43:12]}}),
		.re      (advance),
		.raddr   (raddr),
		.rdata   (matrix_s1)
	);

	lbvs_seq #(.BONE_COUNT(BONE_COUNT)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.load      (load),
		.pos       (s_tdata[139:44]),
		.indices   (s_tdata[171:140]),
		.weights   (s_tdata[235:172]),
		.free      (free),
		.raddr     (raddr),
		.ctl_s1    (ctl_s1),
		.weight_s1 (weight_s1),
		.pos_s1    (pos_s1)
	);

	lbvs_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.ctl_s1    (ctl_s1),
		.weight_s1 (weight_s1),
		.pos_s1    (pos_s1),
		.matrix_s1 (matrix_s1),
		.done_s6   (done_s6),
		.acc_s6    (acc_s6)
	);

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			clip[r] = !((&acc_s6[r][ACC_W-1:31]) || !(|acc_s6[r][ACC_W-1:31]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= done_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 3; r++) begin
				m_data_q[r*32 +: 32] <= clip[r] ?
					(acc_s6[r][ACC_W-1] ? 32'h8000_0000 : 32'h7fff_ffff) :
					acc_s6[r][31:0];
			end
			m_sat_q <= |clip;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = m_data_q;
	assign m_tuser[0] = m_sat_q;

	`LBVS_ASSERT_NEXT(a_skin_holds_input, clk, arst_n, load, !s_tready)
	`LBVS_ASSERT_NOW(a_out_from_done, clk, arst_n, $rose(m_tvalid), $past(done_s6))
	`LBVS_ASSERT_NEXT(a_load_issues, clk, arst_n, load, !free)

endmodule

/* design/lbvs_ram.sv */
module lbvs_ram import lbvs_pkg::*; #(
	parameter int LANE_W = WORD_W,
	parameter int LANES  = WORDS_PER_BONE,
	parameter int DEPTH  = DEF_BONE_COUNT,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                    clk,
	input  logic [LANES-1:0]        we_mask,
	input  logic [AW-1:0]           waddr,
	input  logic [LANES*LANE_W-1:0] wdata,
	input  logic                    re,
	input  logic [AW-1:0]           raddr,
	output logic [LANES*LANE_W-1:0] rdata
);

	logic [LANES*LANE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (we_mask[l]) mem[waddr][l*LANE_W +: LANE_W] <= wdata[l*LANE_W +: LANE_W];
		end
		if (re) rdata <= mem[raddr];
	end

endmodule

/* design/lbvs_seq.sv */
module lbvs_seq import lbvs_pkg::*; #(
	parameter int BONE_COUNT = DEF_BONE_COUNT,
	localparam int AW        = (BONE_COUNT > 1) ? $clog2(BONE_COUNT) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              load,
	input  logic [3*WORD_W-1:0]               pos,
	input  logic [INFLUENCES*8-1:0]           indices,
	input  logic [INFLUENCES*WEIGHT_W-1:0]    weights,
	output logic                              free,
	output logic [AW-1:0]                     raddr,
	output lbvs_ctl_t                         ctl_s1,
	output logic [WEIGHT_W-1:0]               weight_s1,
	output logic [3*WORD_W-1:0]               pos_s1
);

	logic                           busy_q;
	logic [1:0]                     k_q;
	logic [3*WORD_W-1:0]            pos_q;
	logic [INFLUENCES*8-1:0]        idx_q;
	logic [INFLUENCES*WEIGHT_W-1:0] wt_q;
	logic [7:0]                     bone;
	logic                           last;

	assign bone  = idx_q[8*k_q +: 8];
	assign last  = (k_q == 2'(INFLUENCES - 1));
	assign free  = !busy_q || last;
	assign raddr = bone[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			k_q    <= '0;
			ctl_s1 <= '0;
		end else if (advance) begin
			ctl_s1.valid <= busy_q;
			ctl_s1.first <= (k_q == 2'd0);
			ctl_s1.last  <= last;
			ctl_s1.ok    <= ({1'b0, bone} < 9'(BONE_COUNT));
			if (load) begin
				busy_q <= 1'b1;
				k_q    <= '0;
			end else if (busy_q) begin
				k_q <= k_q + 2'd1;
				if (last) busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			weight_s1 <= wt_q[WEIGHT_W*k_q +: WEIGHT_W];
			pos_s1    <= pos_q;
			if (load) begin
				pos_q <= pos;
				idx_q <= indices;
				wt_q  <= weights;
			end
		end
	end

endmodule

/* design/lbvs_mac.sv */
module lbvs_mac import lbvs_pkg::*; #(
	parameter int FRAC_BITS = DEF_FRAC_BITS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           advance,
	input  lbvs_ctl_t                      ctl_s1,
	input  logic [WEIGHT_W-1:0]            weight_s1,
	input  logic [3*WORD_W-1:0]            pos_s1,
	input  logic [WORDS_PER_BONE*WORD_W-1:0] matrix_s1,
	output logic                           done_s6,
	output logic signed [ACC_W-1:0]        acc_s6 [3]
);

	localparam logic signed [63:0] HALF_F = 64'sd1 <<< (FRAC_BITS - 1);
	localparam logic signed [79:0] HALF_W = 80'sd1 <<< (WEIGHT_FRAC - 1);

	lbvs_ctl_t ctl_s2, ctl_s3, ctl_s4, ctl_s5;

	logic signed [63:0]        prod_s2 [9];
	logic signed [WORD_W-1:0]  trans_s2 [3];
	logic [WEIGHT_W-1:0]       w_s2, w_s3;
	logic signed [63:0]        row_s3 [3];
	logic signed [48:0]        hi_s4 [3];
	logic signed [49:0]        lo_s4 [3];
	logic                      neg_s4 [3];
	logic signed [63:0]        wv_s5 [3];

	function automatic logic signed [63:0] rnd_frac(input logic signed [63:0] v);
		logic signed [63:0] t;
		t = v + (v[63] ? (HALF_F - 64'sd1) : HALF_F);
		return t >>> FRAC_BITS;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2  <= '0;
			ctl_s3  <= '0;
			ctl_s4  <= '0;
			ctl_s5  <= '0;
			done_s6 <= 1'b0;
		end else if (advance) begin
			ctl_s2  <= ctl_s1;
			ctl_s3  <= ctl_s2;
			ctl_s4  <= ctl_s3;
			ctl_s5  <= ctl_s4;
			done_s6 <= ctl_s5.valid && ctl_s5.last;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prod_s2[r*3+c] <=
						$signed(matrix_s1[(r*ROW_WORDS+c)*WORD_W +: WORD_W]) *
						$signed(pos_s1[c*WORD_W +: WORD_W]);
				end
				trans_s2[r] <= $signed(matrix_s1[(r*ROW_WORDS+3)*WORD_W +: WORD_W]);
			end
			w_s2 <= weight_s1;

			for (int r = 0; r < 3; r++) begin
				row_s3[r] <= 64'(trans_s2[r]) + rnd_frac(prod_s2[r*3]) +
					rnd_frac(prod_s2[r*3+1]) + rnd_frac(prod_s2[r*3+2]);
			end
			w_s3 <= w_s2;

			for (int r = 0; r < 3; r++) begin
				hi_s4[r]  <= $signed(row_s3[r][63:32]) * $signed({1'b0, w_s3});
				lo_s4[r]  <= $signed({1'b0, row_s3[r][31:0]}) * $signed({1'b0, w_s3});
				neg_s4[r] <= row_s3[r][63];
			end

			for (int r = 0; r < 3; r++) begin
				wv_s5[r] <= 64'((((80'(hi_s4[r]) <<< 32) + 80'(lo_s4[r]) +
					(neg_s4[r] ? (HALF_W - 80'sd1) : HALF_W))) >>> WEIGHT_FRAC);
			end

			if (ctl_s5.valid) begin
				for (int r = 0; r < 3; r++) begin
					acc_s6[r] <= (ctl_s5.first ? 64'sd0 : acc_s6[r]) +
						(ctl_s5.ok ? wv_s5[r] : 64'sd0);
				end
			end
		end
	end

endmodule
